@@ src/ffsa_pkg.sv @@
// ----------------------------------------------------------------------------
// ffsa_pkg: shared definitions for the first-fit segment allocator
// Constants, result codes and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package ffsa_pkg;

  localparam int ADDR_W = 32;
  localparam int DEF_MAX_SEGMENTS = 64;
  localparam int DEF_SIZE_BITS = 28;
  localparam logic [ADDR_W-1:0] RESET_BASE = 32'h0060_0000;
  localparam logic [63:0] RESET_SIZE = 64'd134217728;

  localparam logic REG_HEAP_BASE = 1'b0;
  localparam logic REG_HEAP_SIZE = 1'b1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOFIT    = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FREED    = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_INIT,
    OP_LOAD,
    OP_RD_IDX,
    OP_STEP,
    OP_CAPTURE,
    OP_SET_NOFIT,
    OP_SET_NOTFOUND,
    OP_SET_FULL,
    OP_SET_FREED,
    OP_UP_INIT,
    OP_UP_RD,
    OP_UP_WR,
    OP_SPLIT,
    OP_TAKE,
    OP_REL_TOT,
    OP_NX_CAP,
    OP_MERGE_WR,
    OP_DN_RD,
    OP_DN_WR,
    OP_DN_DONE,
    OP_FIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic init_pend;
    logic out_busy;
    logic mode;
    logic size_zero;
    logic hit;
    logic last;
    logic exact;
    logic full;
    logic cur_free;
    logic up_end;
    logic dn_end;
  } sts_t;

endpackage

@@ src/ffsa_if.sv @@
// ----------------------------------------------------------------------------
// ffsa_req_if / ffsa_rsp_if: request and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ffsa_req_if #(
  parameter int SIZE_BITS = 28
);
  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [SIZE_BITS-1:0] req_size;
  logic [31:0]          req_address;

  modport source (output valid, mode, req_size, req_address, input ready);
  modport sink (input valid, mode, req_size, req_address, output ready);
endinterface

interface ffsa_rsp_if #(
  parameter int SIZE_BITS = 28
);
  logic                 valid;
  logic                 ready;
  logic [2:0]           status;
  logic [31:0]          block_address;
  logic [SIZE_BITS-1:0] free_bytes;
  logic [SIZE_BITS-1:0] used_bytes;

  modport source (output valid, status, block_address, free_bytes, used_bytes,
                  input ready);
  modport sink (input valid, status, block_address, free_bytes, used_bytes,
                output ready);
endinterface

@@ src/ffsa_datapath.sv @@
// ----------------------------------------------------------------------------
// ffsa_datapath: segment table and arithmetic
// Holds the segment table memory, the heap registers, the running totals,
// the scan and shift pointers and the result register.
// ----------------------------------------------------------------------------
module ffsa_datapath import ffsa_pkg::*; #(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int SIZE_BITS = DEF_SIZE_BITS,
  parameter int CFG_DW = (SIZE_BITS > ADDR_W) ? SIZE_BITS : ADDR_W
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [CFG_DW-1:0]    cfg_data,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  logic                 in_mode,
  input  logic [SIZE_BITS-1:0] in_size,
  input  logic [ADDR_W-1:0]    in_address,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_status,
  output logic [ADDR_W-1:0]    out_address,
  output logic [SIZE_BITS-1:0] out_free,
  output logic [SIZE_BITS-1:0] out_used
);

  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  logic [ADDR_W-1:0]    mem_start [MAX_SEGMENTS];
  logic [SIZE_BITS-1:0] mem_len [MAX_SEGMENTS];
  logic                 mem_free [MAX_SEGMENTS];

  logic [ADDR_W-1:0]    rd_start;
  logic [SIZE_BITS-1:0] rd_len;
  logic                 rd_free;

  logic [ADDR_W-1:0]    heap_base;
  logic [SIZE_BITS-1:0] heap_size;
  logic                 init_pend;
  logic [CW-1:0]        count;
  logic [SIZE_BITS-1:0] tfree;
  logic [SIZE_BITS-1:0] tused;

  logic                 req_mode;
  logic [SIZE_BITS-1:0] req_size;
  logic [ADDR_W-1:0]    req_addr;
  logic [IW-1:0]        idx;
  logic [CW-1:0]        ptr;
  logic [1:0]           sh;
  logic [ADDR_W-1:0]    cur_start;
  logic [SIZE_BITS-1:0] cur_len;
  logic                 cur_free;
  logic [ADDR_W-1:0]    prev_start;
  logic [SIZE_BITS-1:0] prev_len;
  logic                 prev_free;
  logic [SIZE_BITS-1:0] nx_len;
  logic                 nx_free;
  status_t              res_status;
  logic [ADDR_W-1:0]    res_addr;

  logic [CW-1:0]        idx_ext;
  logic [CW-1:0]        idx_inc;
  logic                 idx_last;
  logic [CW:0]          dn_src;
  logic                 we;
  logic [IW-1:0]        waddr;
  logic [ADDR_W-1:0]    wstart;
  logic [SIZE_BITS-1:0] wlen;
  logic                 wfree;
  logic [IW-1:0]        raddr;
  logic [CW-1:0]        mg_ptr;
  logic [1:0]           mg_sh;

  assign idx_ext  = CW'(idx);
  assign idx_inc  = idx_ext + CW'(1);
  assign idx_last = idx_inc >= count;
  assign dn_src   = {1'b0, ptr} + (CW+1)'(sh);

  assign sts.init_pend = init_pend;
  assign sts.out_busy  = out_valid && !out_ready;
  assign sts.mode      = req_mode;
  assign sts.size_zero = req_size == '0;
  assign sts.hit       = req_mode ? (rd_start == req_addr)
                                  : (rd_free && (rd_len >= req_size));
  assign sts.last      = idx_last;
  assign sts.exact     = cur_len == req_size;
  assign sts.full      = count == CW'(MAX_SEGMENTS);
  assign sts.cur_free  = cur_free;
  assign sts.up_end    = ptr == idx_ext;
  assign sts.dn_end    = (sh == 2'd0) || (dn_src >= {1'b0, count});

  always_comb begin
    raddr = idx;
    unique case (cmd.op)
      OP_REL_TOT: raddr = IW'(idx_inc);
      OP_UP_RD:   raddr = IW'(ptr);
      OP_DN_RD:   raddr = IW'(dn_src);
      default:    raddr = idx;
    endcase
  end

  always_comb begin
    we     = 1'b0;
    waddr  = idx;
    wstart = cur_start;
    wlen   = cur_len;
    wfree  = 1'b1;
    mg_ptr = idx_ext;
    mg_sh  = 2'd0;
    unique case (cmd.op)
      OP_INIT: begin
        we     = 1'b1;
        waddr  = '0;
        wstart = heap_base;
        wlen   = heap_size;
      end
      OP_UP_WR: begin
        we     = 1'b1;
        waddr  = IW'(ptr + CW'(1));
        wstart = rd_start;
        wlen   = rd_len;
        wfree  = rd_free;
      end
      OP_DN_WR: begin
        we     = 1'b1;
        waddr  = IW'(ptr);
        wstart = rd_start;
        wlen   = rd_len;
        wfree  = rd_free;
      end
      OP_SPLIT: begin
        we     = 1'b1;
        waddr  = IW'(idx_inc);
        wstart = cur_start + ADDR_W'(req_size);
        wlen   = cur_len - req_size;
      end
      OP_TAKE: begin
        we    = 1'b1;
        wlen  = req_size;
        wfree = 1'b0;
      end
      OP_MERGE_WR: begin
        we = 1'b1;
        if (prev_free) begin
          waddr  = IW'(idx_ext - CW'(1));
          wstart = prev_start;
          wlen   = prev_len + cur_len + (nx_free ? nx_len : '0);
          mg_sh  = nx_free ? 2'd2 : 2'd1;
        end else if (nx_free) begin
          wlen   = cur_len + nx_len;
          mg_ptr = idx_inc;
          mg_sh  = 2'd1;
        end
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_start[waddr] <= wstart;
      mem_len[waddr]   <= wlen;
      mem_free[waddr]  <= wfree;
    end
    rd_start <= mem_start[raddr];
    rd_len   <= mem_len[raddr];
    rd_free  <= mem_free[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= RESET_BASE;
      heap_size <= SIZE_BITS'(RESET_SIZE);
      init_pend <= 1'b1;
      count     <= CW'(1);
      tfree     <= SIZE_BITS'(RESET_SIZE);
      tused     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_HEAP_BASE) begin
          heap_base <= ADDR_W'(cfg_data);
          tfree     <= heap_size;
        end else begin
          heap_size <= SIZE_BITS'(cfg_data);
          tfree     <= SIZE_BITS'(cfg_data);
        end
        init_pend <= 1'b1;
        count     <= CW'(1);
        tused     <= '0;
      end else begin
        unique case (cmd.op)
          OP_INIT:    init_pend <= 1'b0;
          OP_SPLIT:   count <= count + CW'(1);
          OP_DN_DONE: count <= count - CW'(sh);
          OP_TAKE: begin
            tfree <= tfree - req_size;
            tused <= tused + req_size;
          end
          OP_REL_TOT: begin
            tfree <= tfree + cur_len;
            tused <= tused - cur_len;
          end
          default: count <= count;
        endcase
      end
      if (cmd.op == OP_FIN) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        req_mode   <= in_mode;
        req_size   <= in_size;
        req_addr   <= in_address;
        idx        <= '0;
        prev_free  <= 1'b0;
        res_status <= ST_OK;
        res_addr   <= '0;
      end
      OP_STEP: begin
        prev_start <= rd_start;
        prev_len   <= rd_len;
        prev_free  <= rd_free;
        idx        <= IW'(idx_inc);
      end
      OP_CAPTURE: begin
        cur_start <= rd_start;
        cur_len   <= rd_len;
        cur_free  <= rd_free;
      end
      OP_NX_CAP: begin
        nx_len  <= rd_len;
        nx_free <= rd_free && !idx_last;
      end
      OP_SET_NOFIT:    res_status <= ST_NOFIT;
      OP_SET_NOTFOUND: res_status <= ST_NOTFOUND;
      OP_SET_FULL:     res_status <= ST_FULL;
      OP_SET_FREED:    res_status <= ST_FREED;
      OP_UP_INIT:      ptr <= count - CW'(1);
      OP_UP_WR:        ptr <= ptr - CW'(1);
      OP_DN_WR:        ptr <= ptr + CW'(1);
      OP_TAKE:         res_addr <= cur_start;
      OP_MERGE_WR: begin
        ptr <= mg_ptr;
        sh  <= mg_sh;
      end
      OP_FIN: begin
        out_status  <= res_status;
        out_address <= res_addr;
        out_free    <= tfree;
        out_used    <= tused;
      end
      default: ptr <= ptr;
    endcase
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count != '0) && (count <= CW'(MAX_SEGMENTS)))
    else $error("segment count out of range");

  a_totals: assert property (@(posedge clk) disable iff (rst)
    SIZE_BITS'(tfree + tused) == heap_size)
    else $error("free and used totals do not add up to the heap size");

  a_fin_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_FIN) |-> !(out_valid && !out_ready))
    else $error("result overwritten while still waiting");

  a_split_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_SPLIT) |-> (count < CW'(MAX_SEGMENTS)))
    else $error("split with a full table");
`endif

endmodule

@@ src/ffsa_ctrl.sv @@
// ----------------------------------------------------------------------------
// ffsa_ctrl: request sequencer
// Steps the datapath through the scan, split, release and merge phases of
// one request at a time.
// ----------------------------------------------------------------------------
module ffsa_ctrl import ffsa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [15:0] {
    S_IDLE     = 16'h0001,
    S_SCAN_RD  = 16'h0002,
    S_SCAN_CHK = 16'h0004,
    S_ALLOC    = 16'h0008,
    S_UP_CHK   = 16'h0010,
    S_UP_RD    = 16'h0020,
    S_UP_WR    = 16'h0040,
    S_SPLIT    = 16'h0080,
    S_TAKE     = 16'h0100,
    S_REL      = 16'h0200,
    S_REL_NX   = 16'h0400,
    S_MERGE    = 16'h0800,
    S_DN_CHK   = 16'h1000,
    S_DN_RD    = 16'h2000,
    S_DN_WR    = 16'h4000,
    S_FIN      = 16'h8000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE) && !sts.init_pend;

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (sts.init_pend) begin
          cmd.op = OP_INIT;
        end else if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        cmd.op     = OP_RD_IDX;
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (!sts.mode && sts.size_zero) begin
          cmd.op     = OP_SET_NOFIT;
          state_next = S_FIN;
        end else if (sts.hit) begin
          cmd.op     = OP_CAPTURE;
          state_next = sts.mode ? S_REL : S_ALLOC;
        end else if (sts.last) begin
          cmd.op     = sts.mode ? OP_SET_NOTFOUND : OP_SET_NOFIT;
          state_next = S_FIN;
        end else begin
          cmd.op     = OP_STEP;
          state_next = S_SCAN_RD;
        end
      end
      S_ALLOC: begin
        if (sts.exact) begin
          state_next = S_TAKE;
        end else if (sts.full) begin
          cmd.op     = OP_SET_FULL;
          state_next = S_FIN;
        end else begin
          cmd.op     = OP_UP_INIT;
          state_next = S_UP_CHK;
        end
      end
      S_UP_CHK: state_next = sts.up_end ? S_SPLIT : S_UP_RD;
      S_UP_RD: begin
        cmd.op     = OP_UP_RD;
        state_next = S_UP_WR;
      end
      S_UP_WR: begin
        cmd.op     = OP_UP_WR;
        state_next = S_UP_CHK;
      end
      S_SPLIT: begin
        cmd.op     = OP_SPLIT;
        state_next = S_TAKE;
      end
      S_TAKE: begin
        cmd.op     = OP_TAKE;
        state_next = S_FIN;
      end
      S_REL: begin
        if (sts.cur_free) begin
          cmd.op     = OP_SET_FREED;
          state_next = S_FIN;
        end else begin
          cmd.op     = OP_REL_TOT;
          state_next = S_REL_NX;
        end
      end
      S_REL_NX: begin
        cmd.op     = OP_NX_CAP;
        state_next = S_MERGE;
      end
      S_MERGE: begin
        cmd.op     = OP_MERGE_WR;
        state_next = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (sts.dn_end) begin
          cmd.op     = OP_DN_DONE;
          state_next = S_FIN;
        end else begin
          state_next = S_DN_RD;
        end
      end
      S_DN_RD: begin
        cmd.op     = OP_DN_RD;
        state_next = S_DN_WR;
      end
      S_DN_WR: begin
        cmd.op     = OP_DN_WR;
        state_next = S_DN_CHK;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.op     = OP_FIN;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ src/first_fit_segment_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_segment_allocator: first-fit heap allocator with coalescing
// One request is handled at a time. The segment table sits in a
// single-port-read memory, so the scan reads and then checks each table
// entry visited, and every entry moved to open or close a gap is checked,
// read and written in turn. After reset or a heap register write, the
// table is rebuilt as one free segment before the next request is taken.
// A finished result waits in an output register while the next request
// is accepted.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator import ffsa_pkg::*; #(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int SIZE_BITS = DEF_SIZE_BITS,
  parameter int CFG_DW = (SIZE_BITS > ADDR_W) ? SIZE_BITS : ADDR_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  ffsa_req_if.sink          req,
  ffsa_rsp_if.source        rsp
);

  cmd_t cmd;
  sts_t sts;

  ffsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ffsa_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .SIZE_BITS    (SIZE_BITS),
    .CFG_DW       (CFG_DW)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .sts         (sts),
    .in_mode     (req.mode),
    .in_size     (req.req_size),
    .in_address  (req.req_address),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .out_status  (rsp.status),
    .out_address (rsp.block_address),
    .out_free    (rsp.free_bytes),
    .out_used    (rsp.used_bytes)
  );

endmodule
